>>> hw/rtl/tnpc_pkg.sv
// Shared types, constants and helper functions of the near-plane clipper.
`timescale 1ns / 1ps

package tnpc_pkg;

  localparam int CW      = 32;            // coordinate width, Q16.16
  localparam int FRAC_W  = 16;            // fraction bits of a coordinate
  localparam int D_W     = CW + 1;        // difference of two coordinates
  localparam int PROD_W  = D_W + CW;      // difference times normal component
  localparam int SUM_W   = PROD_W + 2;    // sum of three such products
  localparam int SIDE_W  = SUM_W - FRAC_W;
  localparam int REM_W   = SIDE_W + 1;    // divider remainder and divisor
  localparam int QUO_W   = 32;            // Q0.32 edge fraction
  localparam int WIDE_W  = D_W + QUO_W + 1;
  localparam int NEAR_W  = 31;
  localparam int ADDR_W  = 5;
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  typedef enum logic [2:0] {
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_NEAR
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_t;

  typedef struct packed {
    coord_t out_a_x;
    coord_t out_a_y;
    coord_t out_a_z;
    coord_t out_b_x;
    coord_t out_b_y;
    coord_t out_b_z;
    coord_t out_c_x;
    coord_t out_c_y;
    coord_t out_c_z;
    logic   last_piece;
  } out_t;

  // One edge intersection on its way through the divider.
  typedef struct packed {
    logic [REM_W-1:0]        rem;
    logic [REM_W-1:0]        den;
    logic [QUO_W-1:0]        quo;
    vtx_t                    o;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic signed [D_W-1:0]   dz;
  } lane_t;

  // Vertices kept for assembling the result triangles.
  typedef struct packed {
    kind_t kind;
    vtx_t  e0;
    vtx_t  e1;
    vtx_t  e2;
  } job_t;

  typedef struct packed {
    job_t  job;
    lane_t lx;
    lane_t ly;
  } qent_t;

  typedef struct packed {
    job_t job;
    vtx_t x;
    vtx_t y;
  } res_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_c(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-CW:0] top;
    top = v[WIDE_W-1:CW-1];
    if (&top || ~|top) begin
      return coord_t'(v[CW-1:0]);
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  function automatic out_t mk_out(input vtx_t a, input vtx_t b, input vtx_t c,
                                  input logic last);
    out_t o;
    o.out_a_x    = a.x;
    o.out_a_y    = a.y;
    o.out_a_z    = a.z;
    o.out_b_x    = b.x;
    o.out_b_y    = b.y;
    o.out_b_z    = b.z;
    o.out_c_x    = c.x;
    o.out_c_y    = c.y;
    o.out_c_z    = c.z;
    o.last_piece = last;
    return o;
  endfunction

endpackage

>>> hw/rtl/triangle_near_plane_clipper_unit.sv
// Top level of the triangle near-plane clipper with its register port.
// The clipper takes one triangle word per accepted input (three vertices in
// signed Q16.16) and clips it against the plane through camera + normal *
// near_distance with the configured normal. A vertex is inside when its
// signed distance to that plane, measured along the normal, is negative.
// A triangle with no vertex inside produces no word, a fully inside one is
// passed through, and a partly inside one produces one or two triangle words
// built from the inside vertices and the edge crossing points; last_piece
// marks the final word of each input. Coordinates that leave the Q16.16
// range saturate. The input side takes a new word every cycle as long as the
// eight-entry queue between front and back has room; the front classifies a
// triangle through its vertex, product and side-value registers, and the back
// finds the edge fractions in a one-bit-per-stage divider followed by the
// intersection point stage. On the output side a two-piece result sends its
// second word from a pending register before the next result is taken.
// Register writes reach the plane point through a two-stage pipeline, the
// scaled-normal register and then the plane point register.
`timescale 1ns / 1ps

module triangle_near_plane_clipper_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tnpc_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tnpc_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tnpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tnpc_pkg::*;

  // Configuration registers.
  coord_t             normal_r [3];
  coord_t             camera_r [3];
  logic [NEAR_W-1:0]  near_r;
  reg_idx_t           reg_idx;
  logic               cfg_we;

  // Plane point pipeline.
  logic signed [2*CW-1:0] pprod_r [3];
  coord_t                 pp_r [3];
  vtx_t                   nrm, pp;

  // Inter-module wiring.
  logic                in_acc;
  logic                push, pop, q_empty;
  qent_t               push_data, pop_data;
  logic [QCNT_W-1:0]   q_count;
  logic [1:0]          inflight;
  logic                take_ok, res_valid;
  res_t                res;
  logic [QCNT_W:0]     used;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r[0] <= '0;
      normal_r[1] <= '0;
      normal_r[2] <= coord_t'(1 << FRAC_W);
      camera_r[0] <= '0;
      camera_r[1] <= '0;
      camera_r[2] <= '0;
      near_r      <= NEAR_W'(1 << FRAC_W);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_NORMAL_X: normal_r[0] <= pwdata;
        REG_NORMAL_Y: normal_r[1] <= pwdata;
        REG_NORMAL_Z: normal_r[2] <= pwdata;
        REG_CAMERA_X: camera_r[0] <= pwdata;
        REG_CAMERA_Y: camera_r[1] <= pwdata;
        REG_CAMERA_Z: camera_r[2] <= pwdata;
        REG_NEAR:     near_r      <= pwdata[NEAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NORMAL_X: prdata = normal_r[0];
      REG_NORMAL_Y: prdata = normal_r[1];
      REG_NORMAL_Z: prdata = normal_r[2];
      REG_CAMERA_X: prdata = camera_r[0];
      REG_CAMERA_Y: prdata = camera_r[1];
      REG_CAMERA_Z: prdata = camera_r[2];
      REG_NEAR:     prdata = {1'b0, near_r};
      default:      prdata = '0;
    endcase
  end

  // Plane point: camera plus normal scaled by the near distance, floored
  // back to Q16.16 and saturated.
  always_ff @(posedge clk) begin
    logic signed [WIDE_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      pprod_r[i] <= normal_r[i] * $signed({1'b0, near_r});
      sum = $signed({{(WIDE_W-CW){camera_r[i][CW-1]}}, camera_r[i]})
          + ($signed({{(WIDE_W-2*CW){pprod_r[i][2*CW-1]}}, pprod_r[i]}) >>> FRAC_W);
      pp_r[i] <= sat_c(sum);
    end
  end

  assign nrm = {normal_r[0], normal_r[1], normal_r[2]};
  assign pp  = {pp_r[0], pp_r[1], pp_r[2]};

  // Room is reserved in the queue for every triangle still in the front.
  assign used     = {1'b0, q_count} + (QCNT_W+1)'(inflight);
  assign in_stall = (used >= (QCNT_W+1)'(QDEPTH));
  assign in_acc   = in_valid && !in_stall;

  tnpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_data   (in_data),
    .nrm       (nrm),
    .pp        (pp),
    .push      (push),
    .push_data (push_data),
    .inflight  (inflight)
  );

  tnpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  tnpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .take_ok   (take_ok),
    .res_valid (res_valid),
    .res       (res)
  );

  tnpc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/tnpc_front.sv
// Front part: side values of the three vertices, classification, edge setup.
`timescale 1ns / 1ps

module tnpc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  tnpc_pkg::in_t   in_data,
  input  tnpc_pkg::vtx_t  nrm,
  input  tnpc_pkg::vtx_t  pp,
  output logic            push,
  output tnpc_pkg::qent_t push_data,
  output logic [1:0]      inflight
);
  import tnpc_pkg::*;

  logic f0_v_r, f1_v_r, f2_v_r;
  vtx_t v0_r [3];
  vtx_t v1_r [3];
  vtx_t v2_r [3];
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [SIDE_W-1:0] s_r   [3];
  logic signed [SIDE_W-1:0] s_nxt [3];

  logic [2:0] ins;
  logic [1:0] n_in;
  logic [1:0] ox, qx, oy, qy, i0, i1, i2, iq, io, iu, iv;
  kind_t      kind;

  function automatic coord_t comp(input vtx_t v, input logic [1:0] k);
    case (k)
      2'd0:    return v.x;
      2'd1:    return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic lane_t lane_init(input vtx_t o, input vtx_t q,
                                      input logic signed [SIDE_W-1:0] so,
                                      input logic signed [SIDE_W-1:0] sq);
    lane_t l;
    l.rem = {1'b0, so};
    l.den = {so[SIDE_W-1], so} - {sq[SIDE_W-1], sq};
    l.quo = '0;
    l.o   = o;
    l.dx  = {q.x[CW-1], q.x} - {o.x[CW-1], o.x};
    l.dy  = {q.y[CW-1], q.y} - {o.y[CW-1], o.y};
    l.dz  = {q.z[CW-1], q.z} - {o.z[CW-1], o.z};
    return l;
  endfunction

  // Products (plane point - vertex) * normal, one per vertex and axis.
  always_comb begin
    coord_t pc, vc, nc;
    logic signed [PROD_W-1:0] de, ne;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pc = comp(pp, 2'(j));
        vc = comp(v0_r[i], 2'(j));
        nc = comp(nrm, 2'(j));
        de = {{(PROD_W-CW){pc[CW-1]}}, pc} - {{(PROD_W-CW){vc[CW-1]}}, vc};
        ne = {{(PROD_W-CW){nc[CW-1]}}, nc};
        prod_nxt[i][j] = de * ne;
      end
    end
  end

  // Exact sum, then floor by dropping the fraction bits.
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = {{2{prod_r[i][0][PROD_W-1]}}, prod_r[i][0]}
          + {{2{prod_r[i][1][PROD_W-1]}}, prod_r[i][1]}
          + {{2{prod_r[i][2][PROD_W-1]}}, prod_r[i][2]};
      s_nxt[i] = sum[SUM_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f0_v_r <= in_acc;
      f1_v_r <= f0_v_r;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      v0_r[0] <= {in_data.a_x, in_data.a_y, in_data.a_z};
      v0_r[1] <= {in_data.b_x, in_data.b_y, in_data.b_z};
      v0_r[2] <= {in_data.c_x, in_data.c_y, in_data.c_z};
    end
    v1_r   <= v0_r;
    prod_r <= prod_nxt;
    v2_r   <= v1_r;
    s_r    <= s_nxt;
  end

  assign inflight = 2'(f0_v_r) + 2'(f1_v_r) + 2'(f2_v_r);

  // A vertex is inside when its side value is negative.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ins[i] = s_r[i][SIDE_W-1];
    end
    n_in = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
    case (n_in)
      2'd0:    kind = KIND_NONE;
      2'd1:    kind = KIND_ONE;
      2'd2:    kind = KIND_TWO;
      default: kind = KIND_ALL;
    endcase

    iq = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
    io = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
    if (ins[0] && ins[2]) begin
      iu = 2'd2;
      iv = 2'd0;
    end else begin
      iu = ins[0] ? 2'd0 : 2'd1;
      iv = ins[2] ? 2'd2 : 2'd1;
    end

    i0 = 2'd0;
    i1 = 2'd1;
    i2 = 2'd2;
    ox = io;
    oy = io;
    qx = iv;
    qy = iu;
    case (kind)
      KIND_ONE: begin
        ox = !ins[0] ? 2'd0 : 2'd1;
        oy = !ins[2] ? 2'd2 : 2'd1;
        qx = iq;
        qy = iq;
        i2 = iq;
      end
      KIND_TWO: begin
        i1 = iu;
        i2 = iv;
      end
      default: begin
      end
    endcase

    push_data.job.kind = kind;
    push_data.job.e0   = v2_r[i0];
    push_data.job.e1   = v2_r[i1];
    push_data.job.e2   = v2_r[i2];
    push_data.lx       = lane_init(v2_r[ox], v2_r[qx], s_r[ox], s_r[qx]);
    push_data.ly       = lane_init(v2_r[oy], v2_r[qy], s_r[oy], s_r[qy]);
    push               = f2_v_r && (kind != KIND_NONE);
  end

endmodule

>>> hw/rtl/tnpc_queue.sv
// Short queue of classified triangles between the front and the back part.
`timescale 1ns / 1ps

module tnpc_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  tnpc_pkg::qent_t            push_data,
  input  logic                       pop,
  output tnpc_pkg::qent_t            pop_data,
  output logic                       empty,
  output logic [tnpc_pkg::QCNT_W-1:0] count
);
  import tnpc_pkg::*;

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop   = pop && (count_r != '0);
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/tnpc_back.sv
// Back part: pipelined edge-fraction divider and intersection point stage.
`timescale 1ns / 1ps

module tnpc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  tnpc_pkg::qent_t q_data,
  output logic            q_pop,
  input  logic            take_ok,
  output logic            res_valid,
  output tnpc_pkg::res_t  res
);
  import tnpc_pkg::*;

  localparam int NSTEP = QUO_W;

  logic  v_r   [NSTEP+1];
  job_t  job_r [NSTEP+1];
  lane_t lx_r  [NSTEP+1];
  lane_t ly_r  [NSTEP+1];

  logic                     m_v_r;
  job_t                     m_job_r;
  vtx_t                     m_ox_r, m_oy_r;
  logic signed [WIDE_W-1:0] m_px_r [3];
  logic signed [WIDE_W-1:0] m_py_r [3];

  logic res_v_r;
  res_t res_r;
  logic en;

  // One restoring division step: one quotient bit.
  function automatic lane_t div_step(input lane_t l);
    lane_t            n;
    logic [REM_W-1:0] r2;
    logic             qb;
    n  = l;
    r2 = {l.rem[REM_W-2:0], 1'b0};
    qb = (r2 >= l.den);
    n.rem = qb ? (r2 - l.den) : r2;
    n.quo = {l.quo[QUO_W-2:0], qb};
    return n;
  endfunction

  function automatic logic signed [WIDE_W-1:0] mulc(
      input logic signed [D_W-1:0] d, input logic [QUO_W-1:0] t);
    logic signed [WIDE_W-1:0] de, te;
    de = {{(WIDE_W-D_W){d[D_W-1]}}, d};
    te = {{(WIDE_W-QUO_W){1'b0}}, t};
    return de * te;
  endfunction

  function automatic coord_t lerp_fin(input coord_t o,
                                      input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] sh, sum;
    sh  = p >>> QUO_W;
    sum = {{(WIDE_W-CW){o[CW-1]}}, o} + sh;
    return sat_c(sum);
  endfunction

  // The whole back part moves together; it holds only when a finished
  // intersection cannot be handed on.
  assign en        = !res_v_r || take_ok;
  assign q_pop     = en && !q_empty;
  assign res_valid = res_v_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTEP; k++) begin
        v_r[k] <= 1'b0;
      end
      m_v_r   <= 1'b0;
      res_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= !q_empty;
      for (int k = 0; k < NSTEP; k++) begin
        v_r[k+1] <= v_r[k];
      end
      m_v_r   <= v_r[NSTEP];
      res_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r[0] <= q_data.job;
      lx_r[0]  <= q_data.lx;
      ly_r[0]  <= q_data.ly;
      for (int k = 0; k < NSTEP; k++) begin
        job_r[k+1] <= job_r[k];
        lx_r[k+1]  <= div_step(lx_r[k]);
        ly_r[k+1]  <= div_step(ly_r[k]);
      end

      m_job_r   <= job_r[NSTEP];
      m_ox_r    <= lx_r[NSTEP].o;
      m_oy_r    <= ly_r[NSTEP].o;
      m_px_r[0] <= mulc(lx_r[NSTEP].dx, lx_r[NSTEP].quo);
      m_px_r[1] <= mulc(lx_r[NSTEP].dy, lx_r[NSTEP].quo);
      m_px_r[2] <= mulc(lx_r[NSTEP].dz, lx_r[NSTEP].quo);
      m_py_r[0] <= mulc(ly_r[NSTEP].dx, ly_r[NSTEP].quo);
      m_py_r[1] <= mulc(ly_r[NSTEP].dy, ly_r[NSTEP].quo);
      m_py_r[2] <= mulc(ly_r[NSTEP].dz, ly_r[NSTEP].quo);

      res_r.job <= m_job_r;
      res_r.x.x <= lerp_fin(m_ox_r.x, m_px_r[0]);
      res_r.x.y <= lerp_fin(m_ox_r.y, m_px_r[1]);
      res_r.x.z <= lerp_fin(m_ox_r.z, m_px_r[2]);
      res_r.y.x <= lerp_fin(m_oy_r.x, m_py_r[0]);
      res_r.y.y <= lerp_fin(m_oy_r.y, m_py_r[1]);
      res_r.y.z <= lerp_fin(m_oy_r.z, m_py_r[2]);
    end
  end

endmodule

>>> hw/rtl/tnpc_emit.sv
// Result assembly: one or two triangle words per job, with output register.
`timescale 1ns / 1ps

module tnpc_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  tnpc_pkg::res_t res,
  output logic           take_ok,
  output logic           out_valid,
  input  logic           out_stall,
  output tnpc_pkg::out_t out_data
);
  import tnpc_pkg::*;

  logic out_valid_r, pend_v_r;
  out_t out_r, pend_r;
  out_t p0, p1;
  logic two, free;

  assign free      = !out_valid_r || !out_stall;
  assign take_ok   = free && !pend_v_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    two = 1'b0;
    p1  = mk_out(res.x, res.job.e1, res.job.e2, 1'b1);
    case (res.job.kind)
      KIND_ONE: begin
        p0 = mk_out(res.x, res.y, res.job.e2, 1'b1);
      end
      KIND_TWO: begin
        p0  = mk_out(res.y, res.job.e1, res.x, 1'b0);
        two = 1'b1;
      end
      default: begin
        p0 = mk_out(res.job.e0, res.job.e1, res.job.e2, 1'b1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else if (free) begin
      if (pend_v_r) begin
        out_valid_r <= 1'b1;
        pend_v_r    <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
        pend_v_r    <= res_valid && two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      if (pend_v_r) begin
        out_r <= pend_r;
      end else if (res_valid) begin
        out_r  <= p0;
        pend_r <= p1;
      end
    end
  end

endmodule

>>> tb/sv/triangle_near_plane_clipper_checker.sv
// Checker for the near-plane clipper: predicts clipped triangles and compares them.
`timescale 1ns / 1ps

module triangle_near_plane_clipper_checker
  import tnpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_t             out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]      pwdata,
  output int               fail_count,
  output int               triangles_due
);

  typedef logic signed [127:0] wide_t;
  typedef struct {
    wide_t c[3];
  } pt_t;

  wide_t normal[3];
  wide_t camera[3];
  wide_t near_dist;
  wide_t plane_pt[3];
  out_t  clipped_q[$];

  function automatic coord_t clamp(wide_t v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Signed distance along the normal, Q16.16, floored.
  function automatic wide_t side_of(pt_t v);
    wide_t acc;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += (plane_pt[i] - v.c[i]) * normal[i];
    return acc >>> 16;
  endfunction

  // Crossing point on the edge from an outside vertex o to an inside vertex q.
  function automatic pt_t crossing(pt_t o, pt_t q);
    wide_t so, sq, frac;
    pt_t   r;
    so = side_of(o);
    sq = side_of(q);
    if (so < 0 || sq >= 0) begin
      for (int i = 0; i < 3; i++) r.c[i] = clamp(o.c[i]);
      return r;
    end
    frac = (so <<< 32) / (so - sq);
    for (int i = 0; i < 3; i++) r.c[i] = clamp(o.c[i] + (((q.c[i] - o.c[i]) * frac) >>> 32));
    return r;
  endfunction

  function automatic out_t make_tri(pt_t a, pt_t b, pt_t c, logic last);
    out_t t;
    t.out_a_x = clamp(a.c[0]); t.out_a_y = clamp(a.c[1]); t.out_a_z = clamp(a.c[2]);
    t.out_b_x = clamp(b.c[0]); t.out_b_y = clamp(b.c[1]); t.out_b_z = clamp(b.c[2]);
    t.out_c_x = clamp(c.c[0]); t.out_c_y = clamp(c.c[1]); t.out_c_z = clamp(c.c[2]);
    t.last_piece = last;
    return t;
  endfunction

  task automatic clip_triangle(in_t t);
    pt_t  p[3];
    pt_t  o, q, a, b, x, y;
    logic ins[3];
    p[0].c[0] = t.a_x; p[0].c[1] = t.a_y; p[0].c[2] = t.a_z;
    p[1].c[0] = t.b_x; p[1].c[1] = t.b_y; p[1].c[2] = t.b_z;
    p[2].c[0] = t.c_x; p[2].c[1] = t.c_y; p[2].c[2] = t.c_z;
    for (int i = 0; i < 3; i++)
      plane_pt[i] = clamp(camera[i] + ((normal[i] * near_dist) >>> 16));
    for (int i = 0; i < 3; i++) ins[i] = side_of(p[i]) < 0;
    if (!ins[0] && !ins[1] && !ins[2]) return;
    if (ins[0] && ins[1] && ins[2]) begin
      clipped_q.push_back(make_tri(p[0], p[1], p[2], 1'b1));
    end else if (ins[0] ^ ins[1] ^ ins[2]) begin
      q = ins[0] ? p[0] : (ins[1] ? p[1] : p[2]);
      x = crossing(!ins[0] ? p[0] : p[1], q);
      y = crossing(!ins[2] ? p[2] : p[1], q);
      clipped_q.push_back(make_tri(x, y, q, 1'b1));
    end else begin
      o = !ins[0] ? p[0] : (!ins[1] ? p[1] : p[2]);
      a = ins[0] ? p[0] : p[1];
      b = ins[2] ? p[2] : p[1];
      // With the first and third vertex inside, the shared point lies on the
      // edge toward the first vertex and the pieces keep that order.
      if (ins[0] && ins[2]) begin
        x = crossing(o, p[0]);
        y = crossing(o, p[2]);
        clipped_q.push_back(make_tri(y, p[2], x, 1'b0));
        clipped_q.push_back(make_tri(x, p[2], p[0], 1'b1));
      end else begin
        x = crossing(o, b);
        y = crossing(o, a);
        clipped_q.push_back(make_tri(y, a, x, 1'b0));
        clipped_q.push_back(make_tri(x, a, b, 1'b1));
      end
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t w;
    if (!rst_n) begin
      normal[0] = 0; normal[1] = 0; normal[2] = 65536;
      camera[0] = 0; camera[1] = 0; camera[2] = 0;
      near_dist = 65536;
      clipped_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_NORMAL_X: normal[0] = $signed(pwdata);
          REG_NORMAL_Y: normal[1] = $signed(pwdata);
          REG_NORMAL_Z: normal[2] = $signed(pwdata);
          REG_CAMERA_X: camera[0] = $signed(pwdata);
          REG_CAMERA_Y: camera[1] = $signed(pwdata);
          REG_CAMERA_Z: camera[2] = $signed(pwdata);
          REG_NEAR:     near_dist = pwdata[NEAR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (clipped_q.size() == 0) begin
          $error("unexpected triangle word %h", out_data);
          fail_count++;
        end else begin
          w = clipped_q.pop_front();
          check_field("out_a_x", w.out_a_x, out_data.out_a_x);
          check_field("out_a_y", w.out_a_y, out_data.out_a_y);
          check_field("out_a_z", w.out_a_z, out_data.out_a_z);
          check_field("out_b_x", w.out_b_x, out_data.out_b_x);
          check_field("out_b_y", w.out_b_y, out_data.out_b_y);
          check_field("out_b_z", w.out_b_z, out_data.out_b_z);
          check_field("out_c_x", w.out_c_x, out_data.out_c_x);
          check_field("out_c_y", w.out_c_y, out_data.out_c_y);
          check_field("out_c_z", w.out_c_z, out_data.out_c_z);
          check_field("last_piece", w.last_piece, out_data.last_piece);
        end
      end
      if (in_valid && !in_stall) clip_triangle(in_data);
    end
    triangles_due = clipped_q.size();
  end

  initial fail_count = 0;

endmodule

>>> tb/sv/triangle_near_plane_clipper_unit_test.sv
// Top of the near-plane clipper testbench: stimulus, stalls, register writes and verdict.
`timescale 1ns / 1ps

module triangle_near_plane_clipper_unit_test;
  import tnpc_pkg::*;

  localparam int ONE = 65536;
  localparam int STUCK_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                triangles_due;

  // Burst bookkeeping for the sender and a request flag for the long hold-off.
  int   burst_left = 0;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  triangle_near_plane_clipper_unit dut (.*);

  triangle_near_plane_clipper_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count, .triangles_due
  );

  // The receiver now and then picks a new stall density at random: none, light
  // or heavy. When a long hold-off is requested it stalls without a break
  // so the eight-entry queue fills and the input side backs up.
  initial begin
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) hold = 300;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_req = 1'b0;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: a stretch with no word moving on either channel ends the run.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STUCK_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one triangle word and hold it until it is taken. Gaps only open
  // between bursts, so valid stays high inside a burst. The stall is looked
  // at mid-cycle, where every output has settled.
  task automatic send_triangle(in_t t);
    bit taken;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid and let every outstanding triangle drain; triangles that make
  // no word may still be in the pipeline, so a latency margin follows. The
  // first edge lets the checker count the word taken at the last edge.
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (triangles_due != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] nd);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_CAMERA_X, cx);
    write_reg(REG_CAMERA_Y, cy);
    write_reg(REG_CAMERA_Z, cz);
    write_reg(REG_NEAR, nd);
  endtask

  // Mostly coordinates within +-16.0 so edges cross the plane often, with
  // some full-range values and the extremes mixed in.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
      default: return $urandom_range(0, 32 * ONE) - 16 * ONE;
    endcase
  endfunction

  function automatic in_t random_triangle();
    in_t t;
    t.a_x = pick_coord(); t.a_y = pick_coord(); t.a_z = pick_coord();
    t.b_x = pick_coord(); t.b_y = pick_coord(); t.b_z = pick_coord();
    t.c_x = pick_coord(); t.c_y = pick_coord(); t.c_z = pick_coord();
    return t;
  endfunction

  // Triangle with chosen depths; under the reset plane a vertex is inside
  // exactly when its z is above 1.0.
  function automatic in_t depth_triangle(int za, int zb, int zc);
    in_t t;
    t = random_triangle();
    t.a_z = za;
    t.b_z = zb;
    t.c_z = zc;
    return t;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_triangle(random_triangle());
  endtask

  initial begin
    in_t t;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset plane: every inside/outside combination
    // of the three vertices, then the coordinate extremes.
    for (int m = 0; m < 8; m++)
      send_triangle(depth_triangle(m[0] ? 2 * ONE : -ONE, m[1] ? 3 * ONE : 0,
                                   m[2] ? 5 * ONE : ONE));
    t = {9{32'h7fffffff}};
    send_triangle(t);
    t = {9{32'h80000000}};
    send_triangle(t);
    t = {3{32'h7fffffff, 32'h80000000, 32'h7fffffff}};
    send_triangle(t);
    t = {32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0, 32'h80000000,
         32'h7fffffff, 32'h80000000, 32'h00020000};
    send_triangle(t);
    send_triangle(depth_triangle(ONE + 1, ONE, 32'h7fffffff));
    random_phase(90);
    drain();

    // A zero normal leaves every vertex outside, so nothing comes back.
    set_plane(0, 0, 0, $urandom, $urandom, $urandom, $urandom);
    random_phase(20);
    drain();

    // Largest normal, camera and distance: the plane point saturates.
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    random_phase(60);
    drain();

    // Smallest values, and a plane right at the camera.
    set_plane(32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
    random_phase(60);
    drain();

    // Moderate random planes through the scene; one of them starts with a
    // long hold-off on the result side while triangles keep coming.
    for (int ph = 0; ph < 6; ph++) begin
      set_plane($urandom_range(0, 4 * ONE) - 2 * ONE, $urandom_range(0, 4 * ONE) - 2 * ONE,
                $urandom_range(0, 4 * ONE) - 2 * ONE, pick_coord(), pick_coord(),
                pick_coord(), $urandom_range(0, 4 * ONE));
      if (ph == 1) hold_req = 1'b1;
      random_phase(90);
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
